// ----- hdl/ggc_pkg.sv -----
// Shared types, widths, constants and helper functions of the go-to-goal controller.
`timescale 1ns / 1ps
package ggc_pkg;

  // Field widths.
  localparam int POS_W   = 24;
  localparam int FRAC_W  = 12;
  localparam int HEAD_W  = 15;
  localparam int GAIN_W  = 16;
  localparam int LIN_W   = 13;
  localparam int RATE_W  = 16;
  localparam int DIST_W  = 25;
  localparam int STAT_W  = 3;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 24;

  // Internal datapath widths.
  localparam int DIFF_W  = POS_W + 2;
  localparam int MAG_W   = POS_W + 1;
  localparam int SQ_W    = 2 * MAG_W + 2;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int DCNT_W  = $clog2(ROOT_W);
  localparam int MUL_W   = DIFF_W + GAIN_W;
  localparam int PROD_W  = MUL_W - FRAC_W;
  localparam int MCNT_W  = $clog2(GAIN_W);
  localparam int WRAP_W  = 18;

  // Vectoring rotator constants.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W      = $clog2(CORDIC_STEPS);
  localparam int TABLE_LEN   = 24;
  localparam int TIDX_W      = $clog2(TABLE_LEN);
  localparam int ANGLE_BITS  = 30;
  localparam int PRESCALE    = 24;
  localparam int CX_W        = DIFF_W + PRESCALE + 2;
  localparam int Z_W         = 34;
  localparam int ANG_SHIFT   = ANGLE_BITS - FRAC_W;
  localparam int ANG_W       = Z_W - ANG_SHIFT;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint PI_FIX  = (PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam longint ONE     = 64'sd1 <<< FRAC_W;
  localparam longint DIST_MAX = (64'sd1 <<< DIST_W) - 1;
  localparam longint RATE_MAX = (64'sd1 <<< (RATE_W - 1)) - 1;
  localparam longint RATE_MIN = -(64'sd1 <<< (RATE_W - 1));

  // Command codes of the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Status codes reported with each result.
  typedef enum logic [STAT_W-1:0] {
    STAT_IDLE     = 3'd0,
    STAT_TURN     = 3'd1,
    STAT_DRIVE    = 3'd2,
    STAT_ALIGN    = 3'd3,
    STAT_REACHED  = 3'd4,
    STAT_CANCELED = 3'd5
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MUL_RATE,
    S_MUL_LIN,
    S_FIN
  } state_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_HEADING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_TOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_TOL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN     = 3'd7;

  // Arctangent of 2^-i in Q30, truncated.
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [TIDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Wrap an angle into [-pi, pi]; two passes each way cover every reachable input.
  function automatic logic signed [WRAP_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] v;
    logic signed [WRAP_W-1:0] pi;
    logic signed [WRAP_W-1:0] twopi;
    pi    = WRAP_W'(PI_FIX);
    twopi = WRAP_W'(2 * PI_FIX);
    v     = a;
    for (int k = 0; k < 2; k++) begin
      if (v > pi) v = v - twopi;
    end
    for (int k = 0; k < 2; k++) begin
      if (v < -pi) v = v + twopi;
    end
    return v;
  endfunction

endpackage

// ----- hdl/ggc_dist.sv -----
// Bit-serial sum of squares followed by a digit-by-digit integer square root.
`timescale 1ns / 1ps
module ggc_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ggc_pkg::DIFF_W-1:0]   dx,
  input  logic signed [ggc_pkg::DIFF_W-1:0]   dy,
  output logic                                done,
  output logic        [ggc_pkg::ROOT_W-1:0]   root
);

  logic [ggc_pkg::SQ_W-1:0]     sq_r, sq_nxt;
  logic [ggc_pkg::SQ_W-1:0]     axm_r, axm_nxt, aym_r, aym_nxt;
  logic [ggc_pkg::MAG_W-1:0]    ax_r, ax_nxt, ay_r, ay_nxt;
  logic [ggc_pkg::ROOT_W+1:0]   rem_r, rem_nxt;
  logic [ggc_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [ggc_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         sq_busy_r, sq_busy_nxt;
  logic                         rt_busy_r, rt_busy_nxt;
  logic                         done_r, done_nxt;

  logic [ggc_pkg::DIFF_W-1:0]   dx_abs, dy_abs;
  logic [ggc_pkg::ROOT_W+1:0]   cur, trial;

  assign dx_abs = dx[ggc_pkg::DIFF_W-1] ? ggc_pkg::DIFF_W'(-dx) : ggc_pkg::DIFF_W'(dx);
  assign dy_abs = dy[ggc_pkg::DIFF_W-1] ? ggc_pkg::DIFF_W'(-dy) : ggc_pkg::DIFF_W'(dy);

  // Root step: bring down the next two bits of the radicand and try to subtract.
  assign cur   = {rem_r[ggc_pkg::ROOT_W-1:0], sq_r[ggc_pkg::SQ_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_comb begin
    sq_nxt      = sq_r;
    axm_nxt     = axm_r;
    aym_nxt     = aym_r;
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    cnt_nxt     = cnt_r;
    sq_busy_nxt = sq_busy_r;
    rt_busy_nxt = rt_busy_r;
    done_nxt    = done_r;
    if (start) begin
      ax_nxt      = dx_abs[ggc_pkg::MAG_W-1:0];
      ay_nxt      = dy_abs[ggc_pkg::MAG_W-1:0];
      axm_nxt     = ggc_pkg::SQ_W'(dx_abs[ggc_pkg::MAG_W-1:0]);
      aym_nxt     = ggc_pkg::SQ_W'(dy_abs[ggc_pkg::MAG_W-1:0]);
      sq_nxt      = '0;
      cnt_nxt     = '0;
      sq_busy_nxt = 1'b1;
      rt_busy_nxt = 1'b0;
      done_nxt    = 1'b0;
    end else if (sq_busy_r) begin
      // One multiplier bit of each square per cycle.
      sq_nxt  = sq_r + (ax_r[0] ? axm_r : '0) + (ay_r[0] ? aym_r : '0);
      axm_nxt = axm_r << 1;
      aym_nxt = aym_r << 1;
      ax_nxt  = ax_r >> 1;
      ay_nxt  = ay_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ggc_pkg::DCNT_W'(ggc_pkg::MAG_W - 1)) begin
        sq_busy_nxt = 1'b0;
        rt_busy_nxt = 1'b1;
        cnt_nxt     = '0;
        rem_nxt     = '0;
        root_nxt    = '0;
      end
    end else if (rt_busy_r) begin
      // One root bit per cycle.
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_r[ggc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_r[ggc_pkg::ROOT_W-2:0], 1'b0};
      end
      sq_nxt  = sq_r << 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ggc_pkg::DCNT_W'(ggc_pkg::ROOT_W - 1)) begin
        rt_busy_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      rt_busy_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      sq_busy_r <= sq_busy_nxt;
      rt_busy_r <= rt_busy_nxt;
      done_r    <= done_nxt;
      cnt_r     <= cnt_nxt;
    end
    sq_r   <= sq_nxt;
    axm_r  <= axm_nxt;
    aym_r  <= aym_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hdl/ggc_cordic.sv -----
// Iterative vectoring rotator that finds the angle of the vector to the goal.
`timescale 1ns / 1ps
module ggc_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [ggc_pkg::DIFF_W-1:0]  dx,
  input  logic signed [ggc_pkg::DIFF_W-1:0]  dy,
  output logic                               done,
  output logic signed [ggc_pkg::ANG_W-1:0]   angle
);

  logic signed [ggc_pkg::CX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ggc_pkg::Z_W-1:0]   z_r, z_nxt;
  logic [ggc_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic                             zero_r, zero_nxt;

  logic signed [ggc_pkg::CX_W-1:0]  x0, y0, xs, ys;
  logic signed [ggc_pkg::Z_W-1:0]   atan_v, z_rnd;

  assign x0     = ggc_pkg::CX_W'(dx) <<< ggc_pkg::PRESCALE;
  assign y0     = ggc_pkg::CX_W'(dy) <<< ggc_pkg::PRESCALE;
  assign xs     = x_r >>> step_r;
  assign ys     = y_r >>> step_r;
  assign atan_v = ggc_pkg::atan_q30(ggc_pkg::TIDX_W'(step_r));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    zero_nxt = zero_r;
    if (start) begin
      // Fold the left half plane onto the right one with a pi offset.
      if (dx < 0) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = (dy >= 0) ? ggc_pkg::Z_W'(ggc_pkg::PI_Q30) : -ggc_pkg::Z_W'(ggc_pkg::PI_Q30);
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
      zero_nxt = (dx == 0) && (dy == 0);
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // Rotate toward the x axis by one table angle per cycle.
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_v;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_v;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == ggc_pkg::STEP_W'(ggc_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  // Round the Q30 accumulator half up to the output fraction.
  assign z_rnd = z_r + ggc_pkg::Z_W'(64'sd1 <<< (ggc_pkg::ANG_SHIFT - 1));
  assign angle = zero_r ? '0 : $signed(z_rnd[ggc_pkg::Z_W-1:ggc_pkg::ANG_SHIFT]);
  assign done  = done_r;

endmodule

// ----- hdl/ggc_mul.sv -----
// Bit-serial gain multiplier with round-half-up rescaling of the product.
`timescale 1ns / 1ps
module ggc_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic        [ggc_pkg::GAIN_W-1:0]  gain,
  input  logic signed [ggc_pkg::DIFF_W-1:0]  val,
  output logic                               done,
  output logic signed [ggc_pkg::PROD_W-1:0]  prod
);

  logic [ggc_pkg::GAIN_W-1:0]       gain_r, gain_nxt;
  logic signed [ggc_pkg::MUL_W-1:0] v_r, v_nxt, acc_r, acc_nxt;
  logic [ggc_pkg::MCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic signed [ggc_pkg::MUL_W-1:0] acc_rnd;

  always_comb begin
    gain_nxt = gain_r;
    v_nxt    = v_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      gain_nxt = gain;
      v_nxt    = ggc_pkg::MUL_W'(val);
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // Add the shifted value for each set gain bit.
      if (gain_r[0]) acc_nxt = acc_r + v_r;
      v_nxt    = v_r <<< 1;
      gain_nxt = gain_r >> 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == ggc_pkg::MCNT_W'(ggc_pkg::GAIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    gain_r <= gain_nxt;
    v_r    <= v_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc_rnd = acc_r + ggc_pkg::MUL_W'(64'sd1 <<< (ggc_pkg::FRAC_W - 1));
  assign prod    = $signed(acc_rnd[ggc_pkg::MUL_W-1:ggc_pkg::FRAC_W]);
  assign done    = done_r;

endmodule

// ----- hdl/go_to_goal_pose_controller.sv -----
// Top level of the proportional go-to-goal pose controller.
// A start or cancel transaction passes through the finish state to the output register. A tick
// transaction runs serial squaring and then root extraction (the angle rotator runs alongside),
// a decision step, a serial gain multiply for the turn rate when turning, driving or aligning,
// a second one for the linear speed when driving, and the finish state to the output register.
// One transaction is in work at a time; the next is taken once the result sits in the
// output register, even while that result is stalled. Command code 3 is taken and dropped.
`timescale 1ns / 1ps
module go_to_goal_pose_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ggc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ggc_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ggc_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [ggc_pkg::POS_W-1:0]    in_pose_x,
  input  logic signed [ggc_pkg::POS_W-1:0]    in_pose_y,
  input  logic signed [ggc_pkg::HEAD_W-1:0]   in_pose_heading,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ggc_pkg::LIN_W-1:0]           out_linear_speed,
  output logic signed [ggc_pkg::RATE_W-1:0]   out_turn_rate,
  output logic [ggc_pkg::DIST_W-1:0]          out_goal_distance,
  output logic signed [ggc_pkg::HEAD_W-1:0]   out_bearing_error,
  output logic [ggc_pkg::STAT_W-1:0]          out_status,
  output logic signed [ggc_pkg::POS_W-1:0]    out_final_x,
  output logic signed [ggc_pkg::POS_W-1:0]    out_final_y
);

  // Configuration registers.
  logic signed [ggc_pkg::POS_W-1:0]  goal_x_r, goal_y_r;
  logic signed [ggc_pkg::HEAD_W-1:0] goal_head_r;
  logic [ggc_pkg::GAIN_W-1:0]        reach_tol_r, align_tol_r, turn_lim_r;
  logic [ggc_pkg::GAIN_W-1:0]        lin_gain_r, ang_gain_r;

  // Sequencer and transaction state.
  ggc_pkg::state_t                   state_r, state_nxt;
  logic                              active_r, active_nxt;
  logic signed [ggc_pkg::POS_W-1:0]  last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic signed [ggc_pkg::HEAD_W-1:0] head_r, head_nxt;
  logic signed [ggc_pkg::DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [ggc_pkg::LIN_W-1:0]         res_lin_r, res_lin_nxt;
  logic signed [ggc_pkg::RATE_W-1:0] res_rate_r, res_rate_nxt;
  logic [ggc_pkg::DIST_W-1:0]        res_dist_r, res_dist_nxt;
  logic signed [ggc_pkg::HEAD_W-1:0] res_bear_r, res_bear_nxt;
  ggc_pkg::status_t                  res_stat_r, res_stat_nxt;

  // Output register.
  logic                              out_valid_r, out_valid_nxt;
  logic [ggc_pkg::LIN_W-1:0]         out_lin_r, out_lin_nxt;
  logic signed [ggc_pkg::RATE_W-1:0] out_rate_r, out_rate_nxt;
  logic [ggc_pkg::DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic signed [ggc_pkg::HEAD_W-1:0] out_bear_r, out_bear_nxt;
  logic [ggc_pkg::STAT_W-1:0]        out_stat_r, out_stat_nxt;
  logic signed [ggc_pkg::POS_W-1:0]  out_fx_r, out_fx_nxt, out_fy_r, out_fy_nxt;

  // Unit handshakes.
  logic                              unit_start;
  logic                              dist_done, cordic_done, mul_done, mul_start;
  logic [ggc_pkg::ROOT_W-1:0]        root;
  logic signed [ggc_pkg::ANG_W-1:0]  angle;
  logic [ggc_pkg::GAIN_W-1:0]        mul_gain;
  logic signed [ggc_pkg::DIFF_W-1:0] mul_val;
  logic signed [ggc_pkg::PROD_W-1:0] prod;

  // Decision datapath.
  logic signed [ggc_pkg::WRAP_W-1:0] bear_w, fd_w;
  logic [ggc_pkg::WRAP_W-1:0]        bear_mag, fd_mag;
  logic [ggc_pkg::DIST_W-1:0]        dist_sat;
  logic                              accept, load_out;

  ggc_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .dx    (dx_nxt),
    .dy    (dy_nxt),
    .done  (dist_done),
    .root  (root)
  );

  ggc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .dx    (dx_nxt),
    .dy    (dy_nxt),
    .done  (cordic_done),
    .angle (angle)
  );

  ggc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .gain  (mul_gain),
    .val   (mul_val),
    .done  (mul_done),
    .prod  (prod)
  );

  assign in_stall = (state_r != ggc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Bearing and final heading error, both wrapped to plus or minus pi.
  assign bear_w   = ggc_pkg::wrap_angle(ggc_pkg::WRAP_W'(angle) - ggc_pkg::WRAP_W'(head_r));
  assign fd_w     = ggc_pkg::wrap_angle(ggc_pkg::WRAP_W'(goal_head_r) -
                                        ggc_pkg::WRAP_W'(head_r));
  assign bear_mag = bear_w[ggc_pkg::WRAP_W-1] ? ggc_pkg::WRAP_W'(-bear_w)
                                              : ggc_pkg::WRAP_W'(bear_w);
  assign fd_mag   = fd_w[ggc_pkg::WRAP_W-1] ? ggc_pkg::WRAP_W'(-fd_w) : ggc_pkg::WRAP_W'(fd_w);
  assign dist_sat = (root > ggc_pkg::ROOT_W'(ggc_pkg::DIST_MAX))
                    ? ggc_pkg::DIST_W'(ggc_pkg::DIST_MAX) : root[ggc_pkg::DIST_W-1:0];

  assign load_out = (state_r == ggc_pkg::S_FIN) && (!out_valid_r || !out_stall);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    head_nxt     = head_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    res_lin_nxt  = res_lin_r;
    res_rate_nxt = res_rate_r;
    res_dist_nxt = res_dist_r;
    res_bear_nxt = res_bear_r;
    res_stat_nxt = res_stat_r;
    unit_start   = 1'b0;
    mul_start    = 1'b0;
    mul_gain     = ang_gain_r;
    mul_val      = ggc_pkg::DIFF_W'(bear_w);
    case (state_r)
      ggc_pkg::S_IDLE: begin
        if (accept) begin
          res_lin_nxt  = '0;
          res_rate_nxt = '0;
          res_dist_nxt = '0;
          res_bear_nxt = '0;
          res_stat_nxt = ggc_pkg::STAT_IDLE;
          case (ggc_pkg::cmd_t'(in_cmd))
            ggc_pkg::CMD_START: begin
              active_nxt = 1'b1;
              state_nxt  = ggc_pkg::S_FIN;
            end
            ggc_pkg::CMD_CANCEL: begin
              res_stat_nxt = active_r ? ggc_pkg::STAT_CANCELED : ggc_pkg::STAT_IDLE;
              active_nxt   = 1'b0;
              state_nxt    = ggc_pkg::S_FIN;
            end
            ggc_pkg::CMD_TICK: begin
              last_x_nxt = in_pose_x;
              last_y_nxt = in_pose_y;
              head_nxt   = in_pose_heading;
              dx_nxt     = ggc_pkg::DIFF_W'(goal_x_r) - ggc_pkg::DIFF_W'(in_pose_x);
              dy_nxt     = ggc_pkg::DIFF_W'(goal_y_r) - ggc_pkg::DIFF_W'(in_pose_y);
              unit_start = 1'b1;
              state_nxt  = ggc_pkg::S_CALC;
            end
            default: state_nxt = ggc_pkg::S_IDLE;
          endcase
        end
      end
      ggc_pkg::S_CALC: begin
        // Pick the control mode once distance and angle are both known.
        if (dist_done && cordic_done) begin
          res_dist_nxt = dist_sat;
          res_bear_nxt = bear_w[ggc_pkg::HEAD_W-1:0];
          state_nxt    = ggc_pkg::S_FIN;
          if (active_r) begin
            if (ggc_pkg::ROOT_W'(dist_sat) > ggc_pkg::ROOT_W'(reach_tol_r)) begin
              mul_start    = 1'b1;
              res_stat_nxt = (bear_mag > ggc_pkg::WRAP_W'(turn_lim_r))
                             ? ggc_pkg::STAT_TURN : ggc_pkg::STAT_DRIVE;
              state_nxt    = ggc_pkg::S_MUL_RATE;
            end else if (fd_mag > ggc_pkg::WRAP_W'(align_tol_r)) begin
              mul_start    = 1'b1;
              mul_val      = ggc_pkg::DIFF_W'(fd_w);
              res_stat_nxt = ggc_pkg::STAT_ALIGN;
              state_nxt    = ggc_pkg::S_MUL_RATE;
            end else begin
              res_stat_nxt = ggc_pkg::STAT_REACHED;
              active_nxt   = 1'b0;
            end
          end
        end
      end
      ggc_pkg::S_MUL_RATE: begin
        // Cap the turn rate at 1.0 while approaching, at the field bounds while aligning.
        if (mul_done) begin
          if (res_stat_r == ggc_pkg::STAT_ALIGN) begin
            if (prod > ggc_pkg::PROD_W'(ggc_pkg::RATE_MAX))
              res_rate_nxt = ggc_pkg::RATE_W'(ggc_pkg::RATE_MAX);
            else if (prod < ggc_pkg::PROD_W'(ggc_pkg::RATE_MIN))
              res_rate_nxt = ggc_pkg::RATE_W'(ggc_pkg::RATE_MIN);
            else
              res_rate_nxt = ggc_pkg::RATE_W'(prod);
          end else begin
            if (prod > ggc_pkg::PROD_W'(ggc_pkg::ONE))
              res_rate_nxt = ggc_pkg::RATE_W'(ggc_pkg::ONE);
            else if (prod < -ggc_pkg::PROD_W'(ggc_pkg::ONE))
              res_rate_nxt = -ggc_pkg::RATE_W'(ggc_pkg::ONE);
            else
              res_rate_nxt = ggc_pkg::RATE_W'(prod);
          end
          if (res_stat_r == ggc_pkg::STAT_DRIVE) begin
            mul_start = 1'b1;
            mul_gain  = lin_gain_r;
            mul_val   = ggc_pkg::DIFF_W'($signed({1'b0, res_dist_r}));
            state_nxt = ggc_pkg::S_MUL_LIN;
          end else begin
            state_nxt = ggc_pkg::S_FIN;
          end
        end
      end
      ggc_pkg::S_MUL_LIN: begin
        if (mul_done) begin
          res_lin_nxt = (prod > ggc_pkg::PROD_W'(ggc_pkg::ONE))
                        ? ggc_pkg::LIN_W'(ggc_pkg::ONE) : ggc_pkg::LIN_W'(prod);
          state_nxt   = ggc_pkg::S_FIN;
        end
      end
      ggc_pkg::S_FIN: begin
        if (load_out) state_nxt = ggc_pkg::S_IDLE;
      end
      default: state_nxt = ggc_pkg::S_IDLE;
    endcase
  end

  // Output register: loads from the finish state, empties when the consumer takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_lin_nxt   = out_lin_r;
    out_rate_nxt  = out_rate_r;
    out_dist_nxt  = out_dist_r;
    out_bear_nxt  = out_bear_r;
    out_stat_nxt  = out_stat_r;
    out_fx_nxt    = out_fx_r;
    out_fy_nxt    = out_fy_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_lin_nxt   = res_lin_r;
      out_rate_nxt  = res_rate_r;
      out_dist_nxt  = res_dist_r;
      out_bear_nxt  = res_bear_r;
      out_stat_nxt  = res_stat_r;
      out_fx_nxt    = last_x_r;
      out_fy_nxt    = last_y_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ggc_pkg::S_IDLE;
      active_r    <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_head_r <= '0;
      reach_tol_r <= ggc_pkg::GAIN_W'(410);
      align_tol_r <= ggc_pkg::GAIN_W'(205);
      turn_lim_r  <= ggc_pkg::GAIN_W'(819);
      lin_gain_r  <= ggc_pkg::GAIN_W'(2048);
      ang_gain_r  <= ggc_pkg::GAIN_W'(3277);
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          ggc_pkg::CFG_GOAL_X:       goal_x_r    <= cfg_wdata[ggc_pkg::POS_W-1:0];
          ggc_pkg::CFG_GOAL_Y:       goal_y_r    <= cfg_wdata[ggc_pkg::POS_W-1:0];
          ggc_pkg::CFG_GOAL_HEADING: goal_head_r <= cfg_wdata[ggc_pkg::HEAD_W-1:0];
          ggc_pkg::CFG_REACH_TOL:    reach_tol_r <= cfg_wdata[ggc_pkg::GAIN_W-1:0];
          ggc_pkg::CFG_ALIGN_TOL:    align_tol_r <= cfg_wdata[ggc_pkg::GAIN_W-1:0];
          ggc_pkg::CFG_TURN_LIMIT:   turn_lim_r  <= cfg_wdata[ggc_pkg::GAIN_W-1:0];
          ggc_pkg::CFG_LIN_GAIN:     lin_gain_r  <= cfg_wdata[ggc_pkg::GAIN_W-1:0];
          ggc_pkg::CFG_ANG_GAIN:     ang_gain_r  <= cfg_wdata[ggc_pkg::GAIN_W-1:0];
          default:                   ang_gain_r  <= ang_gain_r;
        endcase
      end
    end
    head_r     <= head_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    res_lin_r  <= res_lin_nxt;
    res_rate_r <= res_rate_nxt;
    res_dist_r <= res_dist_nxt;
    res_bear_r <= res_bear_nxt;
    res_stat_r <= res_stat_nxt;
    out_lin_r  <= out_lin_nxt;
    out_rate_r <= out_rate_nxt;
    out_dist_r <= out_dist_nxt;
    out_bear_r <= out_bear_nxt;
    out_stat_r <= out_stat_nxt;
    out_fx_r   <= out_fx_nxt;
    out_fy_r   <= out_fy_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_linear_speed  = out_lin_r;
  assign out_turn_rate     = out_rate_r;
  assign out_goal_distance = out_dist_r;
  assign out_bearing_error = out_bear_r;
  assign out_status        = out_stat_r;
  assign out_final_x       = out_fx_r;
  assign out_final_y       = out_fy_r;

  // A result load from the finish state leaves a valid output and an idle sequencer.
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ggc_pkg::S_FIN && load_out) |=> (out_valid_r && state_r == ggc_pkg::S_IDLE))
    else $error("result load did not return the sequencer to idle");

  // Only a driving result carries a forward speed.
  a_speed_only_driving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lin_r != '0) |-> (out_stat_r == ggc_pkg::STAT_DRIVE))
    else $error("forward speed outside driving mode");

  // Approach turn rates stay within plus or minus 1.0.
  a_turn_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == ggc_pkg::STAT_TURN || out_stat_r == ggc_pkg::STAT_DRIVE))
    |-> (out_rate_r <= ggc_pkg::RATE_W'(ggc_pkg::ONE) &&
         out_rate_r >= -ggc_pkg::RATE_W'(ggc_pkg::ONE)))
    else $error("approach turn rate above cap");

  // Once both units finish, the sequencer leaves the calculation state.
  a_calc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ggc_pkg::S_CALC && dist_done && cordic_done) |=> (state_r != ggc_pkg::S_CALC))
    else $error("sequencer stuck after distance and angle were ready");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the go-to-goal pose controller: directed cases and random missions against a predictor.
`timescale 1ns / 1ps
module tb_top;

  // One input transaction.
  typedef struct {
    ggc_pkg::cmd_t                     cmd;
    logic signed [ggc_pkg::POS_W-1:0]  px;
    logic signed [ggc_pkg::POS_W-1:0]  py;
    logic signed [ggc_pkg::HEAD_W-1:0] hd;
  } pose_cmd_t;

  // One expected result transaction.
  typedef struct {
    logic [ggc_pkg::LIN_W-1:0]         lin;
    logic signed [ggc_pkg::RATE_W-1:0] rate;
    logic [ggc_pkg::DIST_W-1:0]        gdist;
    logic signed [ggc_pkg::HEAD_W-1:0] bear;
    logic [ggc_pkg::STAT_W-1:0]        status;
    logic signed [ggc_pkg::POS_W-1:0]  fx;
    logic signed [ggc_pkg::POS_W-1:0]  fy;
  } steer_result_t;

  // Arctangent of 2^-i in Q30, truncated.
  localparam longint ATAN_TBL [16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ggc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ggc_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ggc_pkg::CMD_W-1:0] in_cmd = ggc_pkg::CMD_NONE;
  logic signed [ggc_pkg::POS_W-1:0] in_pose_x = '0;
  logic signed [ggc_pkg::POS_W-1:0] in_pose_y = '0;
  logic signed [ggc_pkg::HEAD_W-1:0] in_pose_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ggc_pkg::LIN_W-1:0] out_linear_speed;
  logic signed [ggc_pkg::RATE_W-1:0] out_turn_rate;
  logic [ggc_pkg::DIST_W-1:0] out_goal_distance;
  logic signed [ggc_pkg::HEAD_W-1:0] out_bearing_error;
  logic [ggc_pkg::STAT_W-1:0] out_status;
  logic signed [ggc_pkg::POS_W-1:0] out_final_x;
  logic signed [ggc_pkg::POS_W-1:0] out_final_y;

  go_to_goal_pose_controller dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Controller copy: registers and state.
  longint goal_x, goal_y, goal_hd;
  longint reach_tol, align_tol, turn_limit, lin_gain, ang_gain;
  bit     armed;
  longint last_x, last_y;

  pose_cmd_t     pending_cmds[$];
  steer_result_t expected_results[$];
  int  error_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  status_seen[6];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint goal_dist(input longint dx, input longint dy);
    longint unsigned ax;
    longint unsigned ay;
    int s;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = (ax >= 64'd2147483648 || ay >= 64'd2147483648) ? 1 : 0;
    ax >>= s;
    ay >>= s;
    return longint'(int_sqrt(ax * ax + ay * ay) << s);
  endfunction

  // Vectoring rotation in Q30, rounded half up to the fraction width.
  function automatic longint goal_angle(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? ggc_pkg::PI_Q30 : -ggc_pkg::PI_Q30;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += ATAN_TBL[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_TBL[i];
      end
    end
    return (z + (64'sd1 <<< (ggc_pkg::ANG_SHIFT - 1))) >>> ggc_pkg::ANG_SHIFT;
  endfunction

  function automatic longint wrap_pi(input longint a);
    while (a > ggc_pkg::PI_FIX) a -= 2 * ggc_pkg::PI_FIX;
    while (a < -ggc_pkg::PI_FIX) a += 2 * ggc_pkg::PI_FIX;
    return a;
  endfunction

  function automatic longint gain_scale(input longint g, input longint v);
    return (g * v + (64'sd1 <<< (ggc_pkg::FRAC_W - 1))) >>> ggc_pkg::FRAC_W;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Work out the result of one accepted transaction and advance the state.
  function automatic void predict_steering(input pose_cmd_t c);
    steer_result_t r;
    longint lin, rate, dist_v, bear, h, dx, dy, mag, fd;
    logic [ggc_pkg::STAT_W-1:0] st;
    lin = 0; rate = 0; dist_v = 0; bear = 0;
    st = ggc_pkg::STAT_IDLE;
    if (c.cmd == ggc_pkg::CMD_NONE) return;
    if (c.cmd == ggc_pkg::CMD_START) begin
      armed = 1'b1;
    end else if (c.cmd == ggc_pkg::CMD_CANCEL) begin
      st = armed ? ggc_pkg::STAT_CANCELED : ggc_pkg::STAT_IDLE;
      armed = 1'b0;
    end else begin
      last_x = c.px;
      last_y = c.py;
      h = c.hd;
      dx = goal_x - last_x;
      dy = goal_y - last_y;
      dist_v = goal_dist(dx, dy);
      bear = wrap_pi(goal_angle(dx, dy) - h);
      if (armed) begin
        if (dist_v > reach_tol) begin
          mag = bear < 0 ? -bear : bear;
          rate = clamp(gain_scale(ang_gain, bear), -ggc_pkg::ONE, ggc_pkg::ONE);
          if (mag > turn_limit) begin
            st = ggc_pkg::STAT_TURN;
          end else begin
            lin = clamp(gain_scale(lin_gain, dist_v), 0, ggc_pkg::ONE);
            st = ggc_pkg::STAT_DRIVE;
          end
        end else begin
          fd = wrap_pi(goal_hd - h);
          mag = fd < 0 ? -fd : fd;
          if (mag > align_tol) begin
            rate = gain_scale(ang_gain, fd);
            st = ggc_pkg::STAT_ALIGN;
          end else begin
            st = ggc_pkg::STAT_REACHED;
            armed = 1'b0;
          end
        end
      end
    end
    r.lin = ggc_pkg::LIN_W'(lin);
    r.rate = ggc_pkg::RATE_W'(clamp(rate, ggc_pkg::RATE_MIN, ggc_pkg::RATE_MAX));
    r.gdist = ggc_pkg::DIST_W'(clamp(dist_v, 0, ggc_pkg::DIST_MAX));
    r.bear = ggc_pkg::HEAD_W'(bear);
    r.status = st;
    r.fx = ggc_pkg::POS_W'(last_x);
    r.fy = ggc_pkg::POS_W'(last_y);
    expected_results.push_back(r);
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  pose_cmd_t cur_cmd;

  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) begin
        predict_steering(cur_cmd);
        accepted_count++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_cmd <= cur_cmd.cmd;
        in_pose_x <= cur_cmd.px;
        in_pose_y <= cur_cmd.py;
        in_pose_heading <= cur_cmd.hd;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result with the oldest expectation; stall pattern changes by mode.
  int stall_mode = 0;
  int mode_left = 0;
  int phase_cnt = 0;

  always @(posedge clk) begin
    steer_result_t e;
    logic next_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (out_status < 6) status_seen[out_status]++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, -1);
        end else begin
          e = expected_results.pop_front();
          if (out_linear_speed !== e.lin) report_mismatch("linear_speed", out_linear_speed, e.lin);
          if (out_turn_rate !== e.rate) report_mismatch("turn_rate", out_turn_rate, e.rate);
          if (out_goal_distance !== e.gdist)
            report_mismatch("goal_distance", out_goal_distance, e.gdist);
          if (out_bearing_error !== e.bear)
            report_mismatch("bearing_error", out_bearing_error, e.bear);
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
          if (out_final_x !== e.fx) report_mismatch("final_x", out_final_x, e.fx);
          if (out_final_y !== e.fy) report_mismatch("final_y", out_final_y, e.fy);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      phase_cnt++;
      case (stall_mode)
        0: next_stall = 1'b0;
        1: next_stall = $urandom_range(0, 1);
        2: next_stall = $urandom_range(0, 7) != 0;
        default: next_stall = (phase_cnt % 5) < 2;
      endcase
      out_stall <= next_stall;
    end
  end

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [ggc_pkg::CFG_IDX_W-1:0] idx, input longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= ggc_pkg::CFG_W'(value);
    case (idx)
      ggc_pkg::CFG_GOAL_X:       goal_x = longint'(signed'(ggc_pkg::POS_W'(value)));
      ggc_pkg::CFG_GOAL_Y:       goal_y = longint'(signed'(ggc_pkg::POS_W'(value)));
      ggc_pkg::CFG_GOAL_HEADING: goal_hd = longint'(signed'(ggc_pkg::HEAD_W'(value)));
      ggc_pkg::CFG_REACH_TOL:    reach_tol = value & 16'hffff;
      ggc_pkg::CFG_ALIGN_TOL:    align_tol = value & 16'hffff;
      ggc_pkg::CFG_TURN_LIMIT:   turn_limit = value & 16'hffff;
      ggc_pkg::CFG_LIN_GAIN:     lin_gain = value & 16'hffff;
      default:                   ang_gain = value & 16'hffff;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_goal(input longint gx, input longint gy, input longint gh,
                          input longint rt, input longint at, input longint tl,
                          input longint lg, input longint ag);
    write_reg(ggc_pkg::CFG_GOAL_X, gx);
    write_reg(ggc_pkg::CFG_GOAL_Y, gy);
    write_reg(ggc_pkg::CFG_GOAL_HEADING, gh);
    write_reg(ggc_pkg::CFG_REACH_TOL, rt);
    write_reg(ggc_pkg::CFG_ALIGN_TOL, at);
    write_reg(ggc_pkg::CFG_TURN_LIMIT, tl);
    write_reg(ggc_pkg::CFG_LIN_GAIN, lg);
    write_reg(ggc_pkg::CFG_ANG_GAIN, ag);
  endtask

  task automatic push_cmd(input ggc_pkg::cmd_t c, input longint x, input longint y,
                          input longint h);
    pose_cmd_t p;
    p.cmd = c;
    p.px = ggc_pkg::POS_W'(x);
    p.py = ggc_pkg::POS_W'(y);
    p.hd = ggc_pkg::HEAD_W'(h);
    pending_cmds.push_back(p);
  endtask

  // Wait until every transaction has gone through, then let a dropped command settle.
  task automatic drain;
    do @(posedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic longint near_goal(input longint g, input longint span);
    return clamp(g + longint'($urandom_range(0, 2 * span)) - span, -8388608, 8388607);
  endfunction

  function automatic longint rand_heading(input longint toward);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 7) return clamp(toward + longint'($urandom_range(0, 600)) - 300, -16384, 16383);
    if (sel < 18) return longint'($urandom_range(0, 25736)) - 12868;
    return longint'(signed'(ggc_pkg::HEAD_W'($urandom)));
  endfunction

  // A mission: start, ticks closing on the goal, sometimes a cancel or stray commands.
  task automatic push_mission;
    int n;
    longint span;
    n = $urandom_range(4, 16);
    push_cmd(ggc_pkg::CMD_START, 0, 0, 0);
    span = $urandom_range(0, 3) == 0 ? 8388607 : $urandom_range(2000, 200000);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0)
        push_cmd(ggc_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      else
        push_cmd(ggc_pkg::CMD_TICK, near_goal(goal_x, span), near_goal(goal_y, span),
                 rand_heading(goal_hd));
      span = span / 2 + 8;
    end
    if ($urandom_range(0, 3) == 0)
      push_cmd(ggc_pkg::CMD_CANCEL, $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(input int count);
    int target;
    target = accepted_count + count;
    while (accepted_count < target) begin
      push_mission();
      do @(posedge clk);
      while (pending_cmds.size() > 8);
    end
    drain();
  endtask

  initial begin
    // Model state after reset.
    goal_x = 0; goal_y = 0; goal_hd = 0;
    reach_tol = 410; align_tol = 205; turn_limit = 819;
    lin_gain = 2048; ang_gain = 3277;
    armed = 1'b0; last_x = 0; last_y = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on reset registers: idle cases, extremes, zero vector, all states.
    push_cmd(ggc_pkg::CMD_CANCEL, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_TICK, 8388607, -8388608, 12868);
    push_cmd(ggc_pkg::CMD_NONE, 1, 1, 1);
    push_cmd(ggc_pkg::CMD_START, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_START, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_TICK, -8388608, 8388607, -12868);
    push_cmd(ggc_pkg::CMD_TICK, -8388608, -8388608, -16384);
    push_cmd(ggc_pkg::CMD_TICK, 8388607, 8388607, 16383);
    push_cmd(ggc_pkg::CMD_TICK, -40960, 0, 0);
    push_cmd(ggc_pkg::CMD_TICK, -40960, 0, 12868);
    push_cmd(ggc_pkg::CMD_TICK, 8192, 0, 12868);
    push_cmd(ggc_pkg::CMD_TICK, 0, 0, 3000);
    push_cmd(ggc_pkg::CMD_TICK, 0, 0, -16384);
    push_cmd(ggc_pkg::CMD_TICK, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_TICK, 100, -100, 0);
    push_cmd(ggc_pkg::CMD_START, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_CANCEL, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_CANCEL, 0, 0, 0);
    drain();

    // Extreme registers: far corner goal, zero tolerances, full gains.
    set_goal(8388607, -8388608, 12868, 0, 0, 0, 65535, 65535);
    push_cmd(ggc_pkg::CMD_START, 0, 0, 0);
    push_cmd(ggc_pkg::CMD_TICK, -8388608, 8388607, -12868);
    push_cmd(ggc_pkg::CMD_TICK, 8388607, -8388608, -12868);
    push_cmd(ggc_pkg::CMD_TICK, 8388607, -8388608, 12868);
    drain();
    random_phase(200);

    set_goal(-8388608, 8388607, -12868, 65535, 65535, 65535, 0, 0);
    random_phase(150);

    set_goal(0, 0, 0, 410, 205, 819, 2048, 3277);
    random_phase(250);

    set_goal($urandom, $urandom, longint'($urandom_range(0, 25736)) - 12868,
             $urandom_range(200, 4000), $urandom_range(100, 2000), $urandom_range(300, 6000),
             $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_phase(300);

    set_goal(-5000, 7000, 6000, 2000, 1500, 12868, 40000, 30000);
    random_phase(280);

    $display("Covered %0d transactions and %0d results over six register settings.",
             accepted_count, result_count);
    $display("Status counts idle/turn/drive/align/reached/canceled: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 0, expected_results.size());
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ggc_pkg.sv
hdl/ggc_dist.sv
hdl/ggc_cordic.sv
hdl/ggc_mul.sv
hdl/go_to_goal_pose_controller.sv
sim/tb_top.sv
